### design/cdf_pkg.sv
// Shared types, constants and coefficient tables for the CDF 9/7 lifting block.
// No dependencies; used by cdf_mac, cdf97_lifting_wavelet_1d and both testbench files.
package cdf_pkg;

  localparam int SAMPLE_W = 32;
  localparam int LEN_W = 7;
  localparam int COEF_W = 18;
  localparam int OPND_W = SAMPLE_W + 1;
  localparam int PROD_W = OPND_W + COEF_W;
  localparam int FRAC_W = 16;
  localparam int RND_W = PROD_W - FRAC_W;
  localparam int SUM_W = RND_W + 1;

  localparam int DEFAULT_MAX_LENGTH = 64;
  localparam int MIN_LENGTH = 4;
  localparam logic [LEN_W-1:0] LENGTH_RESET = 7'd64;

  localparam int CFG_ADDR_W = 1;
  localparam logic [CFG_ADDR_W-1:0] CFG_DIRECTION = 1'b0;
  localparam logic [CFG_ADDR_W-1:0] CFG_LENGTH = 1'b1;

  localparam int PASS_W = 3;
  localparam logic [PASS_W-1:0] LAST_PASS = 3'd4;

  localparam logic signed [COEF_W-1:0] C_P1 = -18'sd103949;
  localparam logic signed [COEF_W-1:0] C_U1 = -18'sd3472;
  localparam logic signed [COEF_W-1:0] C_P2 = 18'sd57862;
  localparam logic signed [COEF_W-1:0] C_U2 = 18'sd29066;
  localparam logic signed [COEF_W-1:0] C_K = 18'sd75340;
  localparam logic signed [COEF_W-1:0] C_INV_K = 18'sd57007;

  typedef struct packed {
    logic signed [OPND_W-1:0]   operand;
    logic signed [COEF_W-1:0]   coeff;
    logic signed [SAMPLE_W-1:0] addend;
  } mac_req_t;

  typedef struct packed {
    logic                     is_scale;
    logic                     start;
    logic signed [COEF_W-1:0] coeff;
  } pass_t;

  // Forward runs four lifting steps then scaling; inverse runs them mirrored.
  function automatic pass_t pass_info(input logic inv, input logic [PASS_W-1:0] pass);
    pass_t p;
    p = '{is_scale: 1'b1, start: 1'b0, coeff: C_K};
    case (pass)
      3'd0: begin
        if (!inv) p = '{is_scale: 1'b0, start: 1'b1, coeff: C_P1};
      end
      3'd1: begin
        p = inv ? '{is_scale: 1'b0, start: 1'b0, coeff: -C_U2}
                : '{is_scale: 1'b0, start: 1'b0, coeff: C_U1};
      end
      3'd2: begin
        p = inv ? '{is_scale: 1'b0, start: 1'b1, coeff: -C_P2}
                : '{is_scale: 1'b0, start: 1'b1, coeff: C_P2};
      end
      3'd3: begin
        p = inv ? '{is_scale: 1'b0, start: 1'b0, coeff: -C_U1}
                : '{is_scale: 1'b0, start: 1'b0, coeff: C_U2};
      end
      3'd4: begin
        if (inv) p = '{is_scale: 1'b0, start: 1'b1, coeff: -C_P1};
      end
      default: p = '{is_scale: 1'b1, start: 1'b0, coeff: C_K};
    endcase
    return p;
  endfunction

  function automatic logic signed [COEF_W-1:0] scale_coeff(input logic inv, input logic odd);
    return (inv ^ odd) ? C_INV_K : C_K;
  endfunction

endpackage

### design/cdf_mac.sv
// Shared two-stage multiply, round-half-up and saturating add unit.
// Depends on cdf_pkg for widths and the request struct.
module cdf_mac (
  input  logic                                  clk,
  input  cdf_pkg::mac_req_t                     req,
  output logic signed [cdf_pkg::SAMPLE_W-1:0]   result
);

  localparam logic signed [cdf_pkg::PROD_W-1:0] ROUND_BIAS =
    cdf_pkg::PROD_W'(1) <<< (cdf_pkg::FRAC_W - 1);
  localparam logic signed [cdf_pkg::SUM_W-1:0] SAT_MAX =
    cdf_pkg::SUM_W'((64'sd1 <<< (cdf_pkg::SAMPLE_W - 1)) - 64'sd1);
  localparam logic signed [cdf_pkg::SUM_W-1:0] SAT_MIN =
    cdf_pkg::SUM_W'(-(64'sd1 <<< (cdf_pkg::SAMPLE_W - 1)));

  logic signed [cdf_pkg::PROD_W-1:0]   prod;
  logic signed [cdf_pkg::SAMPLE_W-1:0] addend;
  logic signed [cdf_pkg::PROD_W-1:0]   shifted;
  logic signed [cdf_pkg::RND_W-1:0]    rounded;
  logic signed [cdf_pkg::SUM_W-1:0]    total;
  logic signed [cdf_pkg::SAMPLE_W-1:0] saturated;

  always_comb begin
    shifted = (prod + ROUND_BIAS) >>> cdf_pkg::FRAC_W;
    rounded = shifted[cdf_pkg::RND_W-1:0];
    total = cdf_pkg::SUM_W'(rounded) + cdf_pkg::SUM_W'(addend);
    if (total > SAT_MAX) begin
      saturated = SAT_MAX[cdf_pkg::SAMPLE_W-1:0];
    end else if (total < SAT_MIN) begin
      saturated = SAT_MIN[cdf_pkg::SAMPLE_W-1:0];
    end else begin
      saturated = total[cdf_pkg::SAMPLE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    prod <= req.operand * req.coeff;
    addend <= req.addend;
    result <= saturated;
  end

endmodule

### design/cdf97_lifting_wavelet_1d.sv
// Top level of the one-dimensional CDF 9/7 lifting wavelet: sample store,
// sequencer and output register. Depends on cdf_pkg and cdf_mac.
//
// Usage: samples arrive as beats on the s_ channel, one per cycle while
// s_tready is high. After signal_length beats (clamped to 4..MAX_LENGTH and
// rounded down to even, n below) the block stops taking input and runs five
// passes over the store through one shared multiply-add unit: a lifting
// element is a neighbour read, self read, multiply, round and write, and a
// scaled element skips the neighbour read. Results leave on the m_ channel,
// each read from the store into the output register, the next only once the
// current one is taken; m_tlast marks the last of the n results. No input is
// taken until the last result has left. When the receiver stalls, the current
// result holds on m_tdata and the sequencer waits. Configuration writes are
// taken whenever cfg_we is high and apply from the block whose last input
// beat follows them. Reset empties the load count, drops m_tvalid and selects
// the forward transform with a length of 64; the store needs no clearing
// since every entry is written before it is read.
module cdf97_lifting_wavelet_1d #(
  parameter int MAX_LENGTH = cdf_pkg::DEFAULT_MAX_LENGTH
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [cdf_pkg::CFG_ADDR_W-1:0]    cfg_addr,
  input  logic [cdf_pkg::LEN_W-1:0]         cfg_data,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [cdf_pkg::SAMPLE_W-1:0]      s_tdata,   // [31:0] sample
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [cdf_pkg::SAMPLE_W-1:0]      m_tdata,   // [31:0] value
  output logic                              m_tlast
);

  localparam int AW = $clog2(MAX_LENGTH);
  localparam int CW = $clog2(MAX_LENGTH + 1);

  typedef enum logic [3:0] {
    ST_LOAD,
    ST_READ_NB,
    ST_READ_SELF,
    ST_MUL,
    ST_ROUND,
    ST_WRITE,
    ST_EMIT_READ,
    ST_EMIT_LOAD,
    ST_EMIT_WAIT
  } state_t;

  state_t state;

  logic                             direction;
  logic [cdf_pkg::LEN_W-1:0]        signal_length;
  logic                             inv;
  logic [CW-1:0]                    len;
  logic [CW-1:0]                    half;
  logic [CW-1:0]                    load_count;
  logic [cdf_pkg::PASS_W-1:0]       pass;
  logic [CW-1:0]                    idx;
  logic signed [cdf_pkg::OPND_W-1:0] nb_sum;

  logic [cdf_pkg::SAMPLE_W-1:0]     store [MAX_LENGTH];
  logic [cdf_pkg::SAMPLE_W-1:0]     rd_a;
  logic [cdf_pkg::SAMPLE_W-1:0]     rd_b;
  logic [AW-1:0]                    rd_addr_a;
  logic [AW-1:0]                    rd_addr_b;
  logic                             wr_en;
  logic [AW-1:0]                    wr_addr;
  logic [cdf_pkg::SAMPLE_W-1:0]     wr_data;

  logic [cdf_pkg::LEN_W-1:0]        len_clamped;
  logic [CW-1:0]                    len_eff;
  logic [CW-1:0]                    load_next;
  logic                             block_done;
  logic                             in_accept;
  cdf_pkg::pass_t                   pinfo;
  cdf_pkg::pass_t                   pinfo_next;
  cdf_pkg::pass_t                   pinfo_first;
  logic [cdf_pkg::PASS_W-1:0]       pass_next;
  logic [CW:0]                      idx_step;
  logic                             pass_done;
  logic [CW-1:0]                    left_l;
  logic [CW-1:0]                    right_l;
  logic [CW-1:0]                    emit_l;
  logic [CW-1:0]                    emit_diff;
  cdf_pkg::mac_req_t                mac_req;
  logic signed [cdf_pkg::SAMPLE_W-1:0] mac_result;

  // Inverse data sits in packed order, so an odd logical index maps past the
  // low-pass half.
  function automatic logic [AW-1:0] phys(input logic inv_mode, input logic [CW-1:0] hlf,
                                         input logic [CW-1:0] j);
    logic [CW-1:0] a;
    if (inv_mode && j[0]) begin
      a = hlf + (j >> 1);
    end else if (inv_mode) begin
      a = j >> 1;
    end else begin
      a = j;
    end
    return a[AW-1:0];
  endfunction

  always_comb begin
    if (signal_length < cdf_pkg::LEN_W'(cdf_pkg::MIN_LENGTH)) begin
      len_clamped = cdf_pkg::LEN_W'(cdf_pkg::MIN_LENGTH);
    end else if (signal_length > cdf_pkg::LEN_W'(MAX_LENGTH)) begin
      len_clamped = cdf_pkg::LEN_W'(MAX_LENGTH);
    end else begin
      len_clamped = signal_length;
    end
    len_eff = CW'(len_clamped & ~cdf_pkg::LEN_W'(1));
    load_next = load_count + CW'(1);
    in_accept = s_tvalid && s_tready;
    block_done = load_next >= len_eff;

    pinfo = cdf_pkg::pass_info(inv, pass);
    pass_next = pass + cdf_pkg::PASS_W'(1);
    pinfo_next = cdf_pkg::pass_info(inv, pass_next);
    pinfo_first = cdf_pkg::pass_info(direction, '0);
    idx_step = {1'b0, idx} + (pinfo.is_scale ? (CW + 1)'(1) : (CW + 1)'(2));
    pass_done = idx_step >= {1'b0, len};

    left_l = (idx != '0) ? idx - CW'(1) : idx + CW'(1);
    right_l = ((idx + CW'(1)) < len) ? idx + CW'(1) : idx - CW'(1);
    emit_diff = idx - half;
    if (inv) begin
      emit_l = idx;
    end else if (idx < half) begin
      emit_l = idx << 1;
    end else begin
      emit_l = (emit_diff << 1) | CW'(1);
    end

    case (state)
      ST_READ_NB:   rd_addr_a = phys(inv, half, left_l);
      ST_EMIT_READ: rd_addr_a = phys(inv, half, emit_l);
      default:      rd_addr_a = phys(inv, half, idx);
    endcase
    rd_addr_b = phys(inv, half, right_l);

    if (state == ST_WRITE) begin
      wr_en = 1'b1;
      wr_addr = phys(inv, half, idx);
      wr_data = mac_result;
    end else begin
      wr_en = in_accept && (load_count < CW'(MAX_LENGTH));
      wr_addr = load_count[AW-1:0];
      wr_data = s_tdata;
    end

    if (pinfo.is_scale) begin
      mac_req.operand = {rd_a[cdf_pkg::SAMPLE_W-1], rd_a};
      mac_req.coeff = cdf_pkg::scale_coeff(inv, idx[0]);
      mac_req.addend = '0;
    end else begin
      mac_req.operand = nb_sum;
      mac_req.coeff = pinfo.coeff;
      mac_req.addend = rd_a;
    end
  end

  assign s_tready = (state == ST_LOAD);

  cdf_mac u_mac (
    .clk    (clk),
    .req    (mac_req),
    .result (mac_result)
  );

  always_ff @(posedge clk) begin
    if (wr_en) begin
      store[wr_addr] <= wr_data;
    end
    rd_a <= store[rd_addr_a];
    rd_b <= store[rd_addr_b];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_LOAD;
      direction <= 1'b0;
      signal_length <= cdf_pkg::LENGTH_RESET;
      inv <= 1'b0;
      len <= '0;
      half <= '0;
      load_count <= '0;
      pass <= '0;
      idx <= '0;
      m_tvalid <= 1'b0;
      m_tlast <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_addr)
          cdf_pkg::CFG_DIRECTION: direction <= cfg_data[0];
          cdf_pkg::CFG_LENGTH:    signal_length <= cfg_data;
          default:                ;
        endcase
      end
      case (state)
        ST_LOAD: begin
          if (in_accept) begin
            if (block_done) begin
              load_count <= '0;
              inv <= direction;
              len <= len_eff;
              half <= len_eff >> 1;
              pass <= '0;
              idx <= CW'(pinfo_first.start);
              state <= pinfo_first.is_scale ? ST_READ_SELF : ST_READ_NB;
            end else begin
              load_count <= load_next;
            end
          end
        end
        ST_READ_NB: state <= ST_READ_SELF;
        ST_READ_SELF: begin
          nb_sum <= $signed({rd_a[cdf_pkg::SAMPLE_W-1], rd_a})
                  + $signed({rd_b[cdf_pkg::SAMPLE_W-1], rd_b});
          state <= ST_MUL;
        end
        ST_MUL: state <= ST_ROUND;
        ST_ROUND: state <= ST_WRITE;
        ST_WRITE: begin
          if (!pass_done) begin
            idx <= idx_step[CW-1:0];
            state <= pinfo.is_scale ? ST_READ_SELF : ST_READ_NB;
          end else if (pass == cdf_pkg::LAST_PASS) begin
            idx <= '0;
            state <= ST_EMIT_READ;
          end else begin
            pass <= pass_next;
            idx <= CW'(pinfo_next.start);
            state <= pinfo_next.is_scale ? ST_READ_SELF : ST_READ_NB;
          end
        end
        ST_EMIT_READ: state <= ST_EMIT_LOAD;
        ST_EMIT_LOAD: begin
          m_tvalid <= 1'b1;
          m_tdata <= rd_a;
          m_tlast <= (idx == len - CW'(1));
          state <= ST_EMIT_WAIT;
        end
        ST_EMIT_WAIT: begin
          if (m_tready) begin
            m_tvalid <= 1'b0;
            if (m_tlast) begin
              state <= ST_LOAD;
            end else begin
              idx <= idx + CW'(1);
              state <= ST_EMIT_READ;
            end
          end
        end
        default: state <= ST_LOAD;
      endcase
    end
  end

  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(s_tready && m_tvalid))
    else $error("Input taken while a result is pending.");

  a_stop_after_block: assert property (@(posedge clk) disable iff (rst)
    (in_accept && block_done) |=> !s_tready)
    else $error("Input still taken after the block was complete.");

  a_last_frees_input: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tready && m_tlast) |=> s_tready)
    else $error("Loading did not resume after the last result.");

  a_index_in_block: assert property (@(posedge clk) disable iff (rst)
    (state == ST_WRITE) |-> (idx < len))
    else $error("Pass index ran past the block length.");

endmodule

### tb/cdf97_lifting_check.sv
// Checker for the CDF 9/7 lifting wavelet: follows register writes and input beats,
// predicts every block in Q16.16 and compares each result beat in order.
// Depends on cdf_pkg; instantiated beside the design by cdf97_lifting_wavelet_1d_test.
module cdf97_lifting_check
  import cdf_pkg::*;
#(
  parameter int MAX_LEN = 64
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [LEN_W-1:0]      cfg_data,
  input  logic                  s_tvalid,
  input  logic                  s_tready,
  input  logic [SAMPLE_W-1:0]   s_tdata,
  input  logic                  m_tvalid,
  input  logic                  m_tready,
  input  logic [SAMPLE_W-1:0]   m_tdata,
  input  logic                  m_tlast,
  output int                    fail_count,
  output int                    pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MEM_AW = $clog2(MAX_LEN);

  localparam longint LIFT_P1 = -103949;
  localparam longint LIFT_U1 = -3472;
  localparam longint LIFT_P2 = 57862;
  localparam longint LIFT_U2 = 29066;
  localparam longint GAIN_K = 75340;
  localparam longint GAIN_INV_K = 57007;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] value;
    logic                       last;
  } coeff_beat_t;

  coeff_beat_t                coeff_fifo[$];
  logic signed [SAMPLE_W-1:0] sample_mem[MAX_LEN];
  logic signed [SAMPLE_W-1:0] lift_buf[MAX_LEN];
  logic [LEN_W-1:0]           fill_count;
  logic [LEN_W-1:0]           length_reg;
  logic                       inverse_mode;

  task automatic flag_mismatch(input string msg);
    if (fail_count < 200) $display("%0t ns  mismatch: %s", $time, msg);
    fail_count++;
  endtask

  function automatic logic signed [SAMPLE_W-1:0] clip32(input longint v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return SAMPLE_W'(v);
  endfunction

  // Round a Q16.16 product half up to an integer: the arithmetic shift floors.
  function automatic longint round_q16(input longint p);
    return (p + 64'sd32768) >>> 16;
  endfunction

  function automatic void lift_step(input int n, input int first, input longint c);
    longint l, r;
    for (int i = first; i < n; i += 2) begin
      l = (i > 0) ? longint'(lift_buf[i-1]) : longint'(lift_buf[i+1]);
      r = (i + 1 < n) ? longint'(lift_buf[i+1]) : longint'(lift_buf[i-1]);
      lift_buf[i] = clip32(longint'(lift_buf[i]) + round_q16(c * (l + r)));
    end
  endfunction

  function automatic void scale_step(input int n, input longint even_c, input longint odd_c);
    for (int i = 0; i < n; i++)
      lift_buf[i] = clip32(round_q16(longint'(lift_buf[i]) * ((i % 2) ? odd_c : even_c)));
  endfunction

  function automatic int block_length(input logic [LEN_W-1:0] raw);
    int n;
    n = int'(raw);
    if (n < MIN_LENGTH) n = MIN_LENGTH;
    if (n > MAX_LEN) n = MAX_LEN;
    return n - (n % 2);
  endfunction

  function automatic void run_transform(input int n);
    int h;
    coeff_beat_t beat;
    h = n / 2;
    if (!inverse_mode) begin
      for (int i = 0; i < n; i++) lift_buf[i] = sample_mem[i];
      lift_step(n, 1, LIFT_P1);
      lift_step(n, 0, LIFT_U1);
      lift_step(n, 1, LIFT_P2);
      lift_step(n, 0, LIFT_U2);
      scale_step(n, GAIN_K, GAIN_INV_K);
      for (int i = 0; i < n; i++) begin
        beat.value = (i < h) ? lift_buf[2*i] : lift_buf[2*(i-h)+1];
        beat.last = (i == n - 1);
        coeff_fifo.push_back(beat);
      end
    end else begin
      for (int i = 0; i < h; i++) begin
        lift_buf[2*i] = sample_mem[i];
        lift_buf[2*i+1] = sample_mem[h+i];
      end
      scale_step(n, GAIN_INV_K, GAIN_K);
      lift_step(n, 0, -LIFT_U2);
      lift_step(n, 1, -LIFT_P2);
      lift_step(n, 0, -LIFT_U1);
      lift_step(n, 1, -LIFT_P1);
      for (int i = 0; i < n; i++) begin
        beat.value = lift_buf[i];
        beat.last = (i == n - 1);
        coeff_fifo.push_back(beat);
      end
    end
  endfunction

  always @(posedge clk) begin : watch
    coeff_beat_t want;
    int n;
    if (rst) begin
      fill_count = '0;
      length_reg = LENGTH_RESET;
      inverse_mode = 1'b0;
      coeff_fifo.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_addr)
          CFG_DIRECTION: inverse_mode = cfg_data[0];
          CFG_LENGTH: length_reg = cfg_data;
          default: ;
        endcase
      end
      if (m_tvalid && m_tready) begin
        if (coeff_fifo.size() == 0) begin
          flag_mismatch($sformatf("result beat %h with none expected", m_tdata));
        end else begin
          want = coeff_fifo.pop_front();
          if (m_tdata !== want.value)
            flag_mismatch($sformatf("value %h, expected %h", m_tdata, want.value));
          if (m_tlast !== want.last)
            flag_mismatch($sformatf("tlast %b, expected %b", m_tlast, want.last));
        end
      end
      if (s_tvalid && s_tready) begin
        if (int'(fill_count) < MAX_LEN) sample_mem[fill_count[MEM_AW-1:0]] = s_tdata;
        fill_count = fill_count + LEN_W'(1);
        n = block_length(length_reg);
        if (int'(fill_count) >= n) begin
          fill_count = '0;
          run_transform(n);
        end
      end
    end
    pending <= coeff_fifo.size();
  end

endmodule

### tb/cdf97_lifting_wavelet_1d_test.sv
// Stimulus and verdict for cdf97_lifting_wavelet_1d: directed and random blocks in both
// directions, random idling on both sides and one long output stall.
// Depends on cdf_pkg, the design and the checker in cdf97_lifting_check.sv.
module cdf97_lifting_wavelet_1d_test;
  timeunit 1ns;
  timeprecision 1ps;
  import cdf_pkg::*;

  localparam int RANDOM_ITEMS = 310;
  localparam int QUIET_LIMIT = 40000;
  localparam int STALL_CYCLES = 3000;
  localparam int SETTLE_CYCLES = 32;
  localparam int TAIL_CYCLES = 1000;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_we = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr = CFG_DIRECTION;
  logic [LEN_W-1:0]      cfg_data = '0;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [SAMPLE_W-1:0]   s_tdata = '0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [SAMPLE_W-1:0]   m_tdata;
  logic                  m_tlast;

  int fail_count;
  int pending;
  int quiet = 0;
  int stall_req = 0;
  int stall_seen = 0;
  int rx_hold = 0;
  int rx_gap = 0;
  bit rx_idle_on = 1'b0;
  bit tx_idle_on = 1'b0;

  always #6 clk = ~clk;

  cdf97_lifting_wavelet_1d u_top (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_addr (cfg_addr),
    .cfg_data (cfg_data),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  cdf97_lifting_check u_check (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_data   (cfg_data),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tlast    (m_tlast),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
      rx_gap <= 0;
      rx_hold <= 0;
    end else if (rx_hold > 0) begin
      m_tready <= 1'b0;
      rx_hold <= rx_hold - 1;
    end else if (stall_seen != stall_req) begin
      stall_seen <= stall_req;
      m_tready <= 1'b0;
      rx_hold <= STALL_CYCLES - 1;
    end else if (rx_gap > 0) begin
      m_tready <= 1'b0;
      rx_gap <= rx_gap - 1;
    end else if (rx_idle_on && $urandom_range(0, 5) == 0) begin
      m_tready <= 1'b0;
      rx_gap <= $urandom_range(0, 15);
    end else begin
      m_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet <= 0;
    end else if (quiet >= QUIET_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  function automatic logic [SAMPLE_W-1:0] random_sample();
    case ($urandom_range(0, 9))
      0: return 32'h7fffffff;
      1: return 32'h80000000;
      2, 3, 4: return SAMPLE_W'($urandom_range(0, 32'h00ffffff)) - 32'h00800000;
      default: return $urandom;
    endcase
  endfunction

  function automatic int fold_length(input int raw);
    int n;
    n = raw;
    if (n < MIN_LENGTH) n = MIN_LENGTH;
    if (n > DEFAULT_MAX_LENGTH) n = DEFAULT_MAX_LENGTH;
    return n - (n % 2);
  endfunction

  function automatic int pick_length();
    case ($urandom_range(0, 9))
      0: return $urandom_range(0, 3);
      1: return $urandom_range(21, 40);
      default: return $urandom_range(4, 20);
    endcase
  endfunction

  task automatic push_sample(input logic [SAMPLE_W-1:0] d);
    if (tx_idle_on && $urandom_range(0, 5) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= d;
    do @(posedge clk); while (!s_tready);
  endtask

  task automatic write_reg(input logic [CFG_ADDR_W-1:0] a, input logic [LEN_W-1:0] v);
    cfg_we <= 1'b1;
    cfg_addr <= a;
    cfg_data <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // With no result pending the design may still be busy, so drain also waits out SETTLE_CYCLES.
  task automatic drain();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin : stimulus
    int sent, blk, raw, n, k;
    sent = 0;
    blk = 0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Saturation at both ends, a length below the minimum.
    write_reg(CFG_LENGTH, 7'd2);
    push_sample(32'h7fffffff);
    push_sample(32'h80000000);
    push_sample(32'h7fffffff);
    push_sample(32'h80000000);
    drain();
    // Inverse with an odd length.
    write_reg(CFG_DIRECTION, 7'd1);
    write_reg(CFG_LENGTH, 7'd5);
    push_sample(32'h80000000);
    push_sample(32'h7fffffff);
    push_sample(32'h00000000);
    push_sample(32'hffffffff);
    drain();
    write_reg(CFG_DIRECTION, 7'd0);
    write_reg(CFG_LENGTH, 7'd3);
    push_sample(32'h00010000);
    push_sample(32'hffff0000);
    push_sample(32'h7fff0000);
    push_sample(32'h00000001);
    drain();
    write_reg(CFG_DIRECTION, 7'd1);
    write_reg(CFG_LENGTH, 7'd0);
    push_sample(32'h00008000);
    push_sample(32'hffff8000);
    push_sample(32'h00000000);
    push_sample(32'h00018000);
    drain();
    // Length cut below the count already loaded: the next beat closes the block.
    write_reg(CFG_DIRECTION, 7'd0);
    write_reg(CFG_LENGTH, 7'd8);
    repeat (6) push_sample(random_sample());
    drain();
    write_reg(CFG_LENGTH, 7'd4);
    write_reg(CFG_DIRECTION, 7'd1);
    push_sample(random_sample());
    drain();

    // The output is held off while the input keeps offering beats.
    write_reg(CFG_DIRECTION, 7'd0);
    write_reg(CFG_LENGTH, 7'd16);
    n = 16;
    stall_req <= stall_req + 1;
    repeat (48) push_sample(random_sample());
    sent += 48;
    drain();

    tx_idle_on = 1'b1;
    rx_idle_on <= 1'b1;
    while (sent < RANDOM_ITEMS) begin
      if (RANDOM_ITEMS - sent < 40) begin
        tx_idle_on = 1'b0;
        rx_idle_on <= 1'b0;
      end else if ($urandom_range(0, 3) == 0) begin
        tx_idle_on = 1'($urandom_range(0, 1));
        rx_idle_on <= 1'($urandom_range(0, 1));
      end
      if (blk == 2 || blk == 7 || $urandom_range(0, 2) != 0) begin
        drain();
        raw = (blk == 2) ? 127 : (blk == 7) ? 64 : pick_length();
        write_reg(CFG_LENGTH, LEN_W'(raw));
        n = fold_length(raw);
        if ($urandom_range(0, 1)) write_reg(CFG_DIRECTION, LEN_W'($urandom_range(0, 1)));
      end
      if (n >= 6 && $urandom_range(0, 7) == 0) begin
        k = $urandom_range(4, n - 1);
        repeat (k) push_sample(random_sample());
        drain();
        raw = $urandom_range(4, k);
        write_reg(CFG_LENGTH, LEN_W'(raw));
        n = fold_length(raw);
        if ($urandom_range(0, 1)) write_reg(CFG_DIRECTION, LEN_W'($urandom_range(0, 1)));
        push_sample(random_sample());
        sent += k + 1;
      end else begin
        repeat (n) push_sample(random_sample());
        sent += n;
      end
      blk++;
    end

    s_tvalid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

### sim.f
design/cdf_pkg.sv
design/cdf_mac.sv
design/cdf97_lifting_wavelet_1d.sv
tb/cdf97_lifting_check.sv
tb/cdf97_lifting_wavelet_1d_test.sv
